// File: rtl/core/wofd_pkg.sv
// ============================================================================
// wofd_pkg
// Shared constants, types and helpers of the wheel odometer finish detector.
// ============================================================================
package wofd_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int COUNT_WIDTH = 32;
    localparam int FIELD_W     = 32;
    localparam int DIST_W      = 48;
    localparam int SCALE_W     = 20;
    localparam int MM_W        = 20;
    localparam int MS_W        = 16;
    localparam int OFFSET_W    = 16;
    localparam int DELTA_W     = 32;
    localparam int DIFF_W      = DELTA_W + 2;
    localparam int PROD_W      = DELTA_W + SCALE_W;
    localparam int SHIFT_UP    = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int SHIFT_DOWN  = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;
    localparam int SCALED_W    = PROD_W + SHIFT_UP;
    localparam int TIMER_W     = 32;
    localparam int TP_W        = 3;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;

    typedef logic [DIST_W-1:0] dist_t;

    localparam dist_t DIST_MAX = {DIST_W{1'b1}};

    typedef enum logic [2:0] {
        REG_LEFT_SCALE   = 3'd0,
        REG_RIGHT_SCALE  = 3'd1,
        REG_ENABLE_MM    = 3'd2,
        REG_CONFIRM_MS   = 3'd3,
        REG_STOP_OFFSET  = 3'd4,
        REG_POINT_B      = 3'd5,
        REG_POINT_C      = 3'd6,
        REG_POINT_D      = 3'd7
    } reg_addr_t;

    typedef enum logic [TP_W-1:0] {
        TP_START  = 3'd0,
        TP_B      = 3'd1,
        TP_C      = 3'd2,
        TP_D      = 3'd3,
        TP_FINISH = 3'd4
    } track_point_t;

    typedef struct packed {
        logic [SCALE_W-1:0]  left_scale;
        logic [SCALE_W-1:0]  right_scale;
        logic [MM_W-1:0]     enable_mm;
        logic [MS_W-1:0]     confirm_ms;
        logic [OFFSET_W-1:0] stop_offset;
        logic [MM_W-1:0]     point_b;
        logic [MM_W-1:0]     point_c;
        logic [MM_W-1:0]     point_d;
    } cfg_t;

    typedef struct packed {
        logic            op;
        logic            clr;
        logic            marker;
        logic [MS_W-1:0] elapsed;
        dist_t           left;
        dist_t           right;
    } wheel_t;

    typedef struct packed {
        dist_t path;
        dist_t left;
        dist_t right;
        logic  enabled;
        logic  confirmed;
        dist_t latched;
        dist_t stop;
    } flags_t;

    typedef struct packed {
        dist_t        path;
        dist_t        left;
        dist_t        right;
        track_point_t track_point;
        logic         enabled;
        logic         done;
        dist_t        marker;
        dist_t        stop;
        logic         reached;
        dist_t        remaining;
    } result_t;

    function automatic dist_t mm_to_dist(input logic [MM_W-1:0] mm);
        dist_t d;
        d = dist_t'(mm);
        return d << FRAC_BITS;
    endfunction

    function automatic dist_t sat_add(input dist_t a, input dist_t b);
        logic [DIST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DIST_W] ? DIST_MAX : s[DIST_W-1:0];
    endfunction

endpackage

// File: rtl/core/wofd_accum.sv
// ============================================================================
// wofd_accum
// Count deltas, per-wheel scaling and saturating wheel distance totals.
// ============================================================================
module wofd_accum
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  wofd_pkg::cfg_t                           cfg,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic                                     op,
    input  logic signed [wofd_pkg::FIELD_W-1:0]      left_count,
    input  logic signed [wofd_pkg::FIELD_W-1:0]      right_count,
    input  logic                                     marker_seen,
    input  logic [wofd_pkg::MS_W-1:0]                elapsed_ms,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output wofd_pkg::wheel_t                         out_data
);
    import wofd_pkg::*;

    // input stage
    logic                          a_valid_reg;
    logic                          a_op_reg;
    logic [COUNT_WIDTH-1:0]        a_left_reg;
    logic [COUNT_WIDTH-1:0]        a_right_reg;
    logic                          a_marker_reg;
    logic [MS_W-1:0]               a_elapsed_reg;
    logic                          a_en;

    logic [COUNT_WIDTH-1:0]        last_left_reg;
    logic [COUNT_WIDTH-1:0]        last_right_reg;
    logic                          baseline_reg;

    logic                          a_clr;
    logic signed [DIFF_W-1:0]      diff_l;
    logic signed [DIFF_W-1:0]      diff_r;
    logic [DIFF_W-1:0]             mag_l;
    logic [DIFF_W-1:0]             mag_r;
    logic [DELTA_W-1:0]            delta_l_next;
    logic [DELTA_W-1:0]            delta_r_next;

    // delta stage
    logic                          b_valid_reg;
    logic                          b_op_reg;
    logic                          b_clr_reg;
    logic                          b_marker_reg;
    logic [MS_W-1:0]               b_elapsed_reg;
    logic [DELTA_W-1:0]            b_delta_l_reg;
    logic [DELTA_W-1:0]            b_delta_r_reg;
    logic                          b_en;
    logic [PROD_W-1:0]             prod_l;
    logic [PROD_W-1:0]             prod_r;
    logic [SCALED_W-1:0]           scaled_l_next;
    logic [SCALED_W-1:0]           scaled_r_next;

    // product stage
    logic                          c_valid_reg;
    logic                          c_op_reg;
    logic                          c_clr_reg;
    logic                          c_marker_reg;
    logic [MS_W-1:0]               c_elapsed_reg;
    logic [SCALED_W-1:0]           c_scaled_l_reg;
    logic [SCALED_W-1:0]           c_scaled_r_reg;
    logic                          c_en;

    dist_t                         left_total_reg;
    dist_t                         right_total_reg;
    logic [SCALED_W:0]             sum_l;
    logic [SCALED_W:0]             sum_r;
    dist_t                         left_total_next;
    dist_t                         right_total_next;

    // output stage
    logic                          d_valid_reg;
    wheel_t                        d_data_reg;
    logic                          d_en;

    assign d_en     = !d_valid_reg || out_ready;
    assign c_en     = !c_valid_reg || d_en;
    assign b_en     = !b_valid_reg || c_en;
    assign a_en     = !a_valid_reg || b_en;
    assign in_ready = a_en;

    always_comb
    begin
        a_clr  = a_op_reg || !baseline_reg;
        diff_l = {{(DIFF_W-COUNT_WIDTH){a_left_reg[COUNT_WIDTH-1]}}, a_left_reg}
               - {{(DIFF_W-COUNT_WIDTH){last_left_reg[COUNT_WIDTH-1]}}, last_left_reg};
        diff_r = {{(DIFF_W-COUNT_WIDTH){a_right_reg[COUNT_WIDTH-1]}}, a_right_reg}
               - {{(DIFF_W-COUNT_WIDTH){last_right_reg[COUNT_WIDTH-1]}}, last_right_reg};
        mag_l  = diff_l[DIFF_W-1] ? DIFF_W'(-diff_l) : DIFF_W'(diff_l);
        mag_r  = diff_r[DIFF_W-1] ? DIFF_W'(-diff_r) : DIFF_W'(diff_r);
        delta_l_next = (|mag_l[DIFF_W-1:DELTA_W]) ? {DELTA_W{1'b1}} : mag_l[DELTA_W-1:0];
        delta_r_next = (|mag_r[DIFF_W-1:DELTA_W]) ? {DELTA_W{1'b1}} : mag_r[DELTA_W-1:0];
        if (a_clr)
        begin
            delta_l_next = '0;
            delta_r_next = '0;
        end
    end

    always_comb
    begin
        prod_l        = PROD_W'(b_delta_l_reg) * PROD_W'(cfg.left_scale);
        prod_r        = PROD_W'(b_delta_r_reg) * PROD_W'(cfg.right_scale);
        scaled_l_next = (SCALED_W'(prod_l) << SHIFT_UP) >> SHIFT_DOWN;
        scaled_r_next = (SCALED_W'(prod_r) << SHIFT_UP) >> SHIFT_DOWN;
    end

    always_comb
    begin
        sum_l = (c_clr_reg ? '0 : (SCALED_W+1)'(left_total_reg))
              + (SCALED_W+1)'(c_scaled_l_reg);
        sum_r = (c_clr_reg ? '0 : (SCALED_W+1)'(right_total_reg))
              + (SCALED_W+1)'(c_scaled_r_reg);
        left_total_next  = (|sum_l[SCALED_W:DIST_W]) ? DIST_MAX : sum_l[DIST_W-1:0];
        right_total_next = (|sum_r[SCALED_W:DIST_W]) ? DIST_MAX : sum_r[DIST_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg     <= 1'b0;
            b_valid_reg     <= 1'b0;
            c_valid_reg     <= 1'b0;
            d_valid_reg     <= 1'b0;
            baseline_reg    <= 1'b0;
            last_left_reg   <= '0;
            last_right_reg  <= '0;
            left_total_reg  <= '0;
            right_total_reg <= '0;
        end
        else
        begin
            if (a_en)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_en)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_en)
            begin
                c_valid_reg <= b_valid_reg;
            end
            if (d_en)
            begin
                d_valid_reg <= c_valid_reg;
            end
            if (a_valid_reg && b_en)
            begin
                baseline_reg   <= 1'b1;
                last_left_reg  <= a_left_reg;
                last_right_reg <= a_right_reg;
            end
            if (c_valid_reg && d_en)
            begin
                left_total_reg  <= left_total_next;
                right_total_reg <= right_total_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && a_en)
        begin
            a_op_reg      <= op;
            a_left_reg    <= left_count[COUNT_WIDTH-1:0];
            a_right_reg   <= right_count[COUNT_WIDTH-1:0];
            a_marker_reg  <= marker_seen;
            a_elapsed_reg <= elapsed_ms;
        end
        if (a_valid_reg && b_en)
        begin
            b_op_reg      <= a_op_reg;
            b_clr_reg     <= a_clr;
            b_marker_reg  <= a_marker_reg;
            b_elapsed_reg <= a_elapsed_reg;
            b_delta_l_reg <= delta_l_next;
            b_delta_r_reg <= delta_r_next;
        end
        if (b_valid_reg && c_en)
        begin
            c_op_reg       <= b_op_reg;
            c_clr_reg      <= b_clr_reg;
            c_marker_reg   <= b_marker_reg;
            c_elapsed_reg  <= b_elapsed_reg;
            c_scaled_l_reg <= scaled_l_next;
            c_scaled_r_reg <= scaled_r_next;
        end
        if (c_valid_reg && d_en)
        begin
            d_data_reg.op      <= c_op_reg;
            d_data_reg.clr     <= c_clr_reg;
            d_data_reg.marker  <= c_marker_reg;
            d_data_reg.elapsed <= c_elapsed_reg;
            d_data_reg.left    <= left_total_next;
            d_data_reg.right   <= right_total_next;
        end
    end

    assign out_valid = d_valid_reg;
    assign out_data  = d_data_reg;

    a_restart_clears_totals: assert property (@(posedge clk) disable iff (!rst_n)
        (d_valid_reg && d_data_reg.op) |-> (d_data_reg.left == '0 && d_data_reg.right == '0))
        else $error("restart transaction left nonzero totals");

    a_totals_match_output: assert property (@(posedge clk) disable iff (!rst_n)
        (c_valid_reg && d_en) |=> (d_data_reg.left == left_total_reg
                                   && d_data_reg.right == right_total_reg))
        else $error("wheel totals and forwarded distances disagree");

endmodule

// File: rtl/core/wofd_finish.sv
// ============================================================================
// wofd_finish
// Path distance, detection enable, marker confirm timer and stop target.
// ============================================================================
module wofd_finish
(
    input  logic               clk,
    input  logic               rst_n,
    input  wofd_pkg::cfg_t     cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  wofd_pkg::wheel_t   in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output wofd_pkg::flags_t   out_data
);
    import wofd_pkg::*;

    logic                e_valid_reg;
    wheel_t              e_data_reg;
    dist_t               e_path_reg;
    logic                e_en;
    logic [DIST_W:0]     path_sum;

    logic                enabled_reg;
    logic                confirmed_reg;
    logic [TIMER_W-1:0]  timer_reg;
    dist_t               first_sight_reg;
    dist_t               latched_reg;
    dist_t               stop_reg;

    logic                en_base;
    logic                conf_base;
    logic [TIMER_W-1:0]  timer_base;
    dist_t               fs_base;
    dist_t               latched_base;
    dist_t               stop_base;

    logic                enabled_next;
    logic                confirmed_next;
    logic [TIMER_W-1:0]  timer_next;
    dist_t               first_sight_next;
    dist_t               latched_next;
    dist_t               stop_next;

    logic [TIMER_W:0]    timer_sum;
    logic [TIMER_W-1:0]  timer_sat;
    dist_t               fs_pick;
    dist_t               offset_dist;
    dist_t               stop_from_path;
    dist_t               stop_from_fs;
    dist_t               stop_pick;

    logic                f_valid_reg;
    flags_t              f_data_reg;
    logic                f_en;

    assign f_en     = !f_valid_reg || out_ready;
    assign e_en     = !e_valid_reg || f_en;
    assign in_ready = e_en;

    assign path_sum = {1'b0, in_data.left} + {1'b0, in_data.right};

    always_comb
    begin
        en_base      = e_data_reg.clr ? 1'b0 : enabled_reg;
        conf_base    = e_data_reg.clr ? 1'b0 : confirmed_reg;
        timer_base   = e_data_reg.clr ? '0 : timer_reg;
        fs_base      = e_data_reg.clr ? '0 : first_sight_reg;
        latched_base = e_data_reg.clr ? '0 : latched_reg;
        stop_base    = e_data_reg.clr ? '0 : stop_reg;

        timer_sum      = {1'b0, timer_base} + (TIMER_W+1)'(e_data_reg.elapsed);
        timer_sat      = timer_sum[TIMER_W] ? {TIMER_W{1'b1}} : timer_sum[TIMER_W-1:0];
        fs_pick        = (timer_base == '0) ? e_path_reg : fs_base;
        offset_dist    = mm_to_dist(MM_W'(cfg.stop_offset));
        stop_from_path = sat_add(e_path_reg, offset_dist);
        stop_from_fs   = sat_add(fs_base, offset_dist);
        stop_pick      = (timer_base == '0) ? stop_from_path : stop_from_fs;

        enabled_next     = en_base;
        confirmed_next   = conf_base;
        timer_next       = timer_base;
        first_sight_next = fs_base;
        latched_next     = latched_base;
        stop_next        = stop_base;

        if (!e_data_reg.op)
        begin
            if (e_path_reg >= mm_to_dist(cfg.enable_mm))
            begin
                enabled_next = 1'b1;
            end
            if (enabled_next && !conf_base)
            begin
                if (e_data_reg.marker)
                begin
                    first_sight_next = fs_pick;
                    timer_next       = timer_sat;
                    if (timer_sat >= TIMER_W'(cfg.confirm_ms))
                    begin
                        confirmed_next = 1'b1;
                        latched_next   = fs_pick;
                        stop_next      = stop_pick;
                    end
                end
                else
                begin
                    timer_next       = '0;
                    first_sight_next = '0;
                end
            end
            else
            begin
                timer_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg     <= 1'b0;
            f_valid_reg     <= 1'b0;
            enabled_reg     <= 1'b0;
            confirmed_reg   <= 1'b0;
            timer_reg       <= '0;
            first_sight_reg <= '0;
            latched_reg     <= '0;
            stop_reg        <= '0;
        end
        else
        begin
            if (e_en)
            begin
                e_valid_reg <= in_valid;
            end
            if (f_en)
            begin
                f_valid_reg <= e_valid_reg;
            end
            if (e_valid_reg && f_en)
            begin
                enabled_reg     <= enabled_next;
                confirmed_reg   <= confirmed_next;
                timer_reg       <= timer_next;
                first_sight_reg <= first_sight_next;
                latched_reg     <= latched_next;
                stop_reg        <= stop_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && e_en)
        begin
            e_data_reg <= in_data;
            e_path_reg <= path_sum[DIST_W:1];
        end
        if (e_valid_reg && f_en)
        begin
            f_data_reg.path      <= e_path_reg;
            f_data_reg.left      <= e_data_reg.left;
            f_data_reg.right     <= e_data_reg.right;
            f_data_reg.enabled   <= enabled_next;
            f_data_reg.confirmed <= confirmed_next;
            f_data_reg.latched   <= latched_next;
            f_data_reg.stop      <= stop_next;
        end
    end

    assign out_valid = f_valid_reg;
    assign out_data  = f_data_reg;

    a_confirm_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
        confirmed_reg |-> enabled_reg)
        else $error("finish confirmed without detection enabled");

    a_stop_beyond_marker: assert property (@(posedge clk) disable iff (!rst_n)
        confirmed_reg |-> (stop_reg >= latched_reg))
        else $error("stop target below latched marker distance");

    a_timer_idle_when_off: assert property (@(posedge clk) disable iff (!rst_n)
        !enabled_reg |-> (timer_reg == '0))
        else $error("marker timer running while detection is off");

endmodule

// File: rtl/core/wofd_report.sv
// ============================================================================
// wofd_report
// Track point, stop status and remaining distance; result register.
// ============================================================================
module wofd_report
(
    input  logic               clk,
    input  logic               rst_n,
    input  wofd_pkg::cfg_t     cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  wofd_pkg::flags_t   in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output wofd_pkg::result_t  out_data
);
    import wofd_pkg::*;

    logic          o_valid_reg;
    result_t       o_data_reg;
    result_t       result_next;
    logic          o_en;

    assign o_en     = !o_valid_reg || out_ready;
    assign in_ready = o_en;

    always_comb
    begin
        result_next.path    = in_data.path;
        result_next.left    = in_data.left;
        result_next.right   = in_data.right;
        result_next.enabled = in_data.enabled;
        result_next.done    = in_data.confirmed;
        result_next.marker  = in_data.latched;
        result_next.stop    = in_data.stop;
        if (in_data.confirmed)
        begin
            result_next.track_point = TP_FINISH;
        end
        else if (in_data.path >= mm_to_dist(cfg.point_d))
        begin
            result_next.track_point = TP_D;
        end
        else if (in_data.path >= mm_to_dist(cfg.point_c))
        begin
            result_next.track_point = TP_C;
        end
        else if (in_data.path >= mm_to_dist(cfg.point_b))
        begin
            result_next.track_point = TP_B;
        end
        else
        begin
            result_next.track_point = TP_START;
        end
        result_next.reached   = in_data.confirmed && (in_data.path >= in_data.stop);
        result_next.remaining = (in_data.confirmed && (in_data.path < in_data.stop))
                              ? (in_data.stop - in_data.path) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (o_en)
        begin
            o_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && o_en)
        begin
            o_data_reg <= result_next;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_data  = o_data_reg;

    a_reached_no_remaining: assert property (@(posedge clk) disable iff (!rst_n)
        (o_valid_reg && o_data_reg.reached) |-> (o_data_reg.remaining == '0))
        else $error("stop reached with distance still remaining");

endmodule

// File: rtl/core/wheel_odometer_finish_detector_unit.sv
// ============================================================================
// wheel_odometer_finish_detector_unit
// Wheel odometer with finish marker detection and stop target, top level.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready) carries one update or restart per
//   transaction: op, raw left/right encoder counts, marker_seen, elapsed_ms.
//   Output channel (out_valid/out_ready) returns exactly one result per
//   input transaction, in order: distances, track point, flags, stop data.
//   The APB port sets scales, thresholds and timing; write only while idle.
//   Throughput: one transaction per cycle while out_ready is high. The
//   wheel total add and the finish/timer update each feed back within
//   their own stage, so nothing stalls back-to-back transactions; the
//   two 32x20 scale multipliers have a stage of their own.
//   Each stage holds its transaction until the next stage frees up, so a
//   stalled receiver fills the pipeline bubbles first; in_ready drops only
//   when all seven stages hold a transaction.
//   Reset: registers return to their defaults, all state clears, and the
//   first update after reset takes its counts as the baseline.
// ============================================================================
module wheel_odometer_finish_detector_unit
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [wofd_pkg::ADDR_W-1:0]           paddr,
    input  logic [wofd_pkg::DATA_W-1:0]           pwdata,
    output logic [wofd_pkg::DATA_W-1:0]           prdata,
    output logic                                  pready,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  op,
    input  logic signed [wofd_pkg::FIELD_W-1:0]   left_count,
    input  logic signed [wofd_pkg::FIELD_W-1:0]   right_count,
    input  logic                                  marker_seen,
    input  logic [wofd_pkg::MS_W-1:0]             elapsed_ms,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [wofd_pkg::DIST_W-1:0]           path_distance,
    output logic [wofd_pkg::DIST_W-1:0]           left_distance,
    output logic [wofd_pkg::DIST_W-1:0]           right_distance,
    output logic [wofd_pkg::TP_W-1:0]             track_point,
    output logic                                  detect_enabled,
    output logic                                  finish_done,
    output logic [wofd_pkg::DIST_W-1:0]           marker_distance,
    output logic [wofd_pkg::DIST_W-1:0]           stop_distance,
    output logic                                  stop_reached,
    output logic [wofd_pkg::DIST_W-1:0]           remaining_to_stop
);
    import wofd_pkg::*;

    cfg_t        cfg_reg;
    reg_addr_t   reg_addr;
    logic        cfg_write;

    logic        acc_valid;
    logic        acc_ready;
    wheel_t      acc_data;
    logic        fin_valid;
    logic        fin_ready;
    flags_t      fin_data;
    result_t     result;

    assign pready    = 1'b1;
    assign reg_addr  = reg_addr_t'(paddr[ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.left_scale  <= SCALE_W'(65536);
            cfg_reg.right_scale <= SCALE_W'(65536);
            cfg_reg.enable_mm   <= '0;
            cfg_reg.confirm_ms  <= MS_W'(30);
            cfg_reg.stop_offset <= OFFSET_W'(168);
            cfg_reg.point_b     <= '0;
            cfg_reg.point_c     <= '0;
            cfg_reg.point_d     <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_addr)
                REG_LEFT_SCALE:  cfg_reg.left_scale  <= pwdata[SCALE_W-1:0];
                REG_RIGHT_SCALE: cfg_reg.right_scale <= pwdata[SCALE_W-1:0];
                REG_ENABLE_MM:   cfg_reg.enable_mm   <= pwdata[MM_W-1:0];
                REG_CONFIRM_MS:  cfg_reg.confirm_ms  <= pwdata[MS_W-1:0];
                REG_STOP_OFFSET: cfg_reg.stop_offset <= pwdata[OFFSET_W-1:0];
                REG_POINT_B:     cfg_reg.point_b     <= pwdata[MM_W-1:0];
                REG_POINT_C:     cfg_reg.point_c     <= pwdata[MM_W-1:0];
                REG_POINT_D:     cfg_reg.point_d     <= pwdata[MM_W-1:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_addr)
            REG_LEFT_SCALE:  prdata = DATA_W'(cfg_reg.left_scale);
            REG_RIGHT_SCALE: prdata = DATA_W'(cfg_reg.right_scale);
            REG_ENABLE_MM:   prdata = DATA_W'(cfg_reg.enable_mm);
            REG_CONFIRM_MS:  prdata = DATA_W'(cfg_reg.confirm_ms);
            REG_STOP_OFFSET: prdata = DATA_W'(cfg_reg.stop_offset);
            REG_POINT_B:     prdata = DATA_W'(cfg_reg.point_b);
            REG_POINT_C:     prdata = DATA_W'(cfg_reg.point_c);
            REG_POINT_D:     prdata = DATA_W'(cfg_reg.point_d);
            default:         prdata = '0;
        endcase
    end

    wofd_accum u_accum
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .left_count  (left_count),
        .right_count (right_count),
        .marker_seen (marker_seen),
        .elapsed_ms  (elapsed_ms),
        .out_valid   (acc_valid),
        .out_ready   (acc_ready),
        .out_data    (acc_data)
    );

    wofd_finish u_finish
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (acc_valid),
        .in_ready  (acc_ready),
        .in_data   (acc_data),
        .out_valid (fin_valid),
        .out_ready (fin_ready),
        .out_data  (fin_data)
    );

    wofd_report u_report
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (fin_valid),
        .in_ready  (fin_ready),
        .in_data   (fin_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (result)
    );

    assign path_distance     = result.path;
    assign left_distance     = result.left;
    assign right_distance    = result.right;
    assign track_point       = result.track_point;
    assign detect_enabled    = result.enabled;
    assign finish_done       = result.done;
    assign marker_distance   = result.marker;
    assign stop_distance     = result.stop;
    assign stop_reached      = result.reached;
    assign remaining_to_stop = result.remaining;

endmodule
